[hdl/bole_pkg.sv]
// Shared types and codes for the bounded ordered list engine.
package bole_pkg;

	typedef enum logic [2:0] {
		OP_APPEND     = 3'd0,
		OP_INSERT     = 3'd1,
		OP_REMOVE_AT  = 3'd2,
		OP_REMOVE_VAL = 3'd3,
		OP_CONTAINS   = 3'd4,
		OP_SET        = 3'd5,
		OP_GET        = 3'd6,
		OP_CLEAR      = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_RANGE    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_SHIFT_UP,
		S_SHIFT_DN,
		S_GET_DATA,
		S_RESULT
	} state_t;

	localparam int IN_VALUE_W  = 32;
	localparam int POSITION_W  = 6;
	localparam int COUNT_OUT_W = 7;
	localparam int CAP_W       = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef struct packed {
		op_t                    opcode;
		logic [IN_VALUE_W-1:0]  entry_value;
		logic [POSITION_W-1:0]  position;
	} req_t;

	typedef struct packed {
		status_t                status;
		logic [IN_VALUE_W-1:0]  read_value;
		logic [COUNT_OUT_W-1:0] entry_count;
	} rsp_t;

endpackage

[hdl/bounded_ordered_list_engine_top.sv]
// Top level of the bounded ordered list engine: sequencer around one list memory.
//
// The list lives in a single-port-write, single-port-read memory of MAX_ENTRIES words with a
// registered read, plus a count register; there is no clearing pass after reset. One request
// is worked on at a time. Insert and remove at index move one entry per cycle through the
// memory port. Remove by value and contains scan one entry per cycle from the head, and
// remove by value then shifts the tail down over the match. The result sits in an output
// register, so the next request is taken while an earlier result still waits. The capacity
// register is written through cfg_we/cfg_wdata; 0 acts as 1 and values above MAX_ENTRIES act
// as MAX_ENTRIES.
module bounded_ordered_list_engine_top #(
	parameter int MAX_ENTRIES = 64,
	parameter int VALUE_BITS  = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  bole_pkg::req_t                    req,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output bole_pkg::rsp_t                    rsp,
	input  logic                              cfg_we,
	input  logic [bole_pkg::CAP_W-1:0]        cfg_wdata
);

	localparam int AW    = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (CNT_W > bole_pkg::CAP_W) ? CNT_W : bole_pkg::CAP_W;

	// List storage.
	logic [VALUE_BITS-1:0] mem [MAX_ENTRIES];
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [VALUE_BITS-1:0] mem_wdata;
	logic                  mem_re;
	logic [AW-1:0]         mem_raddr;
	logic [VALUE_BITS-1:0] rdata_q;

	bole_pkg::state_t  state_q, state_d;
	logic [bole_pkg::CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  ptr_q, ptr_d;
	logic              rv_s1, rv_d;
	logic [AW-1:0]     idx_s1, idx_d;
	bole_pkg::op_t     op_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [bole_pkg::POSITION_W-1:0] pos_q;
	bole_pkg::status_t status_q, status_d;
	logic [VALUE_BITS-1:0] rd_q, rd_d;
	logic              rsp_valid_q;
	bole_pkg::rsp_t    rsp_q;
	logic              rsp_load;

	logic [CNT_W-1:0]  cap_eff;
	logic [CNT_W-1:0]  ptr_p1, ptr_m1, idx_p1;
	logic [CMP_W-1:0]  pos_w, cnt_w;
	logic              full, hit;

	assign req_ready = (state_q == bole_pkg::S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (CMP_W'(capacity_q) > CMP_W'(MAX_ENTRIES)) begin
			cap_eff = CNT_W'(MAX_ENTRIES);
		end else begin
			cap_eff = CNT_W'(capacity_q);
		end
	end

	assign ptr_p1 = ptr_q + CNT_W'(1);
	assign ptr_m1 = ptr_q - CNT_W'(1);
	assign idx_p1 = CNT_W'(idx_s1) + CNT_W'(1);
	assign pos_w  = CMP_W'(pos_q);
	assign cnt_w  = CMP_W'(count_q);
	assign full   = (count_q >= cap_eff);
	assign hit    = rv_s1 && (rdata_q == val_q);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		ptr_d     = ptr_q;
		rv_d      = 1'b0;
		idx_d     = idx_s1;
		status_d  = status_q;
		rd_d      = rd_q;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = val_q;
		mem_re    = 1'b0;
		mem_raddr = '0;
		rsp_load  = 1'b0;
		unique case (state_q)
			bole_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = bole_pkg::S_EXEC;
				end
			end
			bole_pkg::S_EXEC: begin
				status_d = bole_pkg::ST_OK;
				rd_d     = '0;
				state_d  = bole_pkg::S_RESULT;
				unique case (op_q)
					bole_pkg::OP_APPEND: begin
						if (full) begin
							status_d = bole_pkg::ST_FULL;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = count_q[AW-1:0];
							count_d   = count_q + CNT_W'(1);
						end
					end
					bole_pkg::OP_INSERT: begin
						if (full) begin
							status_d = bole_pkg::ST_FULL;
						end else if (pos_w > cnt_w) begin
							status_d = bole_pkg::ST_RANGE;
						end else begin
							ptr_d   = count_q;
							state_d = bole_pkg::S_SHIFT_UP;
						end
					end
					bole_pkg::OP_REMOVE_AT: begin
						if (pos_w >= cnt_w) begin
							status_d = bole_pkg::ST_RANGE;
						end else begin
							ptr_d   = CNT_W'(pos_w) + CNT_W'(1);
							state_d = bole_pkg::S_SHIFT_DN;
						end
					end
					bole_pkg::OP_REMOVE_VAL,
					bole_pkg::OP_CONTAINS: begin
						ptr_d   = '0;
						state_d = bole_pkg::S_SCAN;
					end
					bole_pkg::OP_SET: begin
						if (pos_w >= cnt_w) begin
							status_d = bole_pkg::ST_RANGE;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = pos_w[AW-1:0];
						end
					end
					bole_pkg::OP_GET: begin
						if (pos_w >= cnt_w) begin
							status_d = bole_pkg::ST_RANGE;
						end else begin
							mem_re    = 1'b1;
							mem_raddr = pos_w[AW-1:0];
							state_d   = bole_pkg::S_GET_DATA;
						end
					end
					bole_pkg::OP_CLEAR: begin
						count_d = '0;
					end
					default: begin
						count_d = '0;
					end
				endcase
			end
			bole_pkg::S_SCAN: begin
				// Each read is compared in the cycle after it is issued; the next read goes out only on a miss.
				if (hit) begin
					if (op_q == bole_pkg::OP_CONTAINS) begin
						state_d = bole_pkg::S_RESULT;
					end else begin
						ptr_d   = idx_p1;
						state_d = bole_pkg::S_SHIFT_DN;
					end
				end else if (ptr_q < count_q) begin
					mem_re    = 1'b1;
					mem_raddr = ptr_q[AW-1:0];
					rv_d      = 1'b1;
					idx_d     = ptr_q[AW-1:0];
					ptr_d     = ptr_p1;
				end else if (!rv_s1) begin
					status_d = bole_pkg::ST_NOTFOUND;
					state_d  = bole_pkg::S_RESULT;
				end
			end
			bole_pkg::S_SHIFT_DN: begin
				// Entry ptr moves to ptr - 1; the write follows in the cycle after the read.
				if (rv_s1) begin
					mem_we    = 1'b1;
					mem_waddr = idx_s1;
					mem_wdata = rdata_q;
				end
				if (ptr_q < count_q) begin
					mem_re    = 1'b1;
					mem_raddr = ptr_q[AW-1:0];
					rv_d      = 1'b1;
					idx_d     = ptr_m1[AW-1:0];
					ptr_d     = ptr_p1;
				end else if (!rv_s1) begin
					count_d = count_q - CNT_W'(1);
					state_d = bole_pkg::S_RESULT;
				end
			end
			bole_pkg::S_SHIFT_UP: begin
				// Entry ptr - 1 moves to ptr, walking down from the tail to the insert point.
				if (rv_s1) begin
					mem_we    = 1'b1;
					mem_waddr = idx_s1;
					mem_wdata = rdata_q;
				end
				if (CMP_W'(ptr_q) > pos_w) begin
					mem_re    = 1'b1;
					mem_raddr = ptr_m1[AW-1:0];
					rv_d      = 1'b1;
					idx_d     = ptr_q[AW-1:0];
					ptr_d     = ptr_m1;
				end else if (!rv_s1) begin
					mem_we    = 1'b1;
					mem_waddr = pos_w[AW-1:0];
					count_d   = count_q + CNT_W'(1);
					state_d   = bole_pkg::S_RESULT;
				end
			end
			bole_pkg::S_GET_DATA: begin
				rd_d    = rdata_q;
				state_d = bole_pkg::S_RESULT;
			end
			bole_pkg::S_RESULT: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = bole_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bole_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bole_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= bole_pkg::CAP_RESET;
			count_q     <= '0;
			ptr_q       <= '0;
			rv_s1       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			count_q <= count_d;
			ptr_q   <= ptr_d;
			rv_s1   <= rv_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= idx_d;
		status_q <= status_d;
		rd_q     <= rd_d;
		if (req_valid && req_ready) begin
			op_q  <= req.opcode;
			val_q <= VALUE_BITS'(req.entry_value);
			pos_q <= req.position;
		end
		if (rsp_load) begin
			rsp_q.status      <= status_q;
			rsp_q.read_value  <= bole_pkg::IN_VALUE_W'(rd_q);
			rsp_q.entry_count <= bole_pkg::COUNT_OUT_W'(count_q);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

endmodule

[tb/testbench.sv]
// Self-checking testbench for the bounded ordered list engine: list mirror, stimulus, checks.
module testbench;
	import bole_pkg::*;

	localparam int DEPTH = 64;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 150;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 195;

	// Mirror of the list contents; it predicts one response per accepted request.
	class list_mirror;
		logic [IN_VALUE_W-1:0] slots[DEPTH];
		int unsigned fill;
		logic [CAP_W-1:0] cap_reg;
		rsp_t pending_results[$];
		int mismatches;

		function new();
			fill = 0;
			cap_reg = CAP_RESET;
			mismatches = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] v);
			cap_reg = v;
		endfunction

		function int unsigned usable_capacity();
			if (cap_reg == 0)
				return 1;
			if (cap_reg > DEPTH)
				return DEPTH;
			return 32'(cap_reg);
		endfunction

		function int find_first(logic [IN_VALUE_W-1:0] v);
			for (int i = 0; i < fill; i++)
				if (slots[i] == v)
					return i;
			return -1;
		endfunction

		function void drop_slot(int unsigned pos);
			for (int unsigned i = pos; i + 1 < fill; i++)
				slots[i] = slots[i + 1];
			fill--;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void record_request(req_t r);
			rsp_t want;
			int hit;
			want.status = ST_OK;
			want.read_value = '0;
			case (r.opcode)
				OP_APPEND: begin
					if (fill >= usable_capacity())
						want.status = ST_FULL;
					else begin
						slots[fill] = r.entry_value;
						fill++;
					end
				end
				OP_INSERT: begin
					// Fullness wins over a bad position.
					if (fill >= usable_capacity())
						want.status = ST_FULL;
					else if (r.position > fill)
						want.status = ST_RANGE;
					else begin
						for (int unsigned i = fill; i > r.position; i--)
							slots[i] = slots[i - 1];
						slots[r.position] = r.entry_value;
						fill++;
					end
				end
				OP_REMOVE_AT: begin
					if (r.position >= fill)
						want.status = ST_RANGE;
					else
						drop_slot(r.position);
				end
				OP_REMOVE_VAL: begin
					hit = find_first(r.entry_value);
					if (hit < 0)
						want.status = ST_NOTFOUND;
					else
						drop_slot(hit);
				end
				OP_CONTAINS: begin
					if (find_first(r.entry_value) < 0)
						want.status = ST_NOTFOUND;
				end
				OP_SET: begin
					if (r.position >= fill)
						want.status = ST_RANGE;
					else
						slots[r.position] = r.entry_value;
				end
				OP_GET: begin
					if (r.position >= fill)
						want.status = ST_RANGE;
					else
						want.read_value = slots[r.position];
				end
				default: begin
					fill = 0;
				end
			endcase
			want.entry_count = fill[COUNT_OUT_W-1:0];
			pending_results.push_back(want);
		endfunction

		function void compare_response(rsp_t got);
			rsp_t want;
			if (pending_results.size() == 0) begin
				$error("response with no request outstanding: status %0d read_value %h count %0d",
					got.status, got.read_value, got.entry_count);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				mismatches++;
			end
			if (got.read_value !== want.read_value) begin
				$error("read_value: expected %h, actual %h", want.read_value, got.read_value);
				mismatches++;
			end
			if (got.entry_count !== want.entry_count) begin
				$error("entry_count: expected %0d, actual %0d", want.entry_count, got.entry_count);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;

	list_mirror mirror;
	bit gaps_on = 1'b0;
	bit stalls_on = 1'b0;
	int stall_left = 0;
	int idle_run = 0;

	bounded_ordered_list_engine_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Response side: check each accepted response, then decide whether to stall.
	always @(posedge clk) begin
		if (rsp_valid && rsp_ready)
			mirror.compare_response(rsp);
		if (stall_left != 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else if (stalls_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 8);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_run = 0;
		else
			idle_run++;
		if (idle_run >= WATCHDOG_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	task automatic issue(input op_t op, input logic [IN_VALUE_W-1:0] value,
			input logic [POSITION_W-1:0] pos);
		req_t r;
		int gap;
		r.opcode = op;
		r.entry_value = value;
		r.position = pos;
		gap = 0;
		if (gaps_on && $urandom_range(0, 4) == 0)
			gap = $urandom_range(1, 9);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		mirror.record_request(r);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (mirror.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		drain_results();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		mirror.set_capacity(v);
	endtask

	// Random request biased toward positions and values that hit the current list.
	task automatic random_request(input int grow_pct, input int clear_pct);
		int unsigned n;
		int unsigned roll;
		op_t op;
		logic [IN_VALUE_W-1:0] v;
		logic [POSITION_W-1:0] p;
		n = mirror.fill;
		roll = $urandom_range(0, 99);
		if (roll < grow_pct)
			op = ($urandom_range(0, 1) != 0) ? OP_APPEND : OP_INSERT;
		else if (roll >= 100 - clear_pct)
			op = OP_CLEAR;
		else
			op = op_t'($urandom_range(1, 6));
		case ($urandom_range(0, 3))
			0: v = $urandom;
			1: v = $urandom_range(0, 15);
			default: v = (n != 0) ? mirror.slots[$urandom_range(0, n - 1)] : $urandom;
		endcase
		if (n == 0 || $urandom_range(0, 4) == 0)
			p = POSITION_W'($urandom_range(0, DEPTH - 1));
		else
			p = POSITION_W'($urandom_range(0, (n > DEPTH - 1) ? DEPTH - 1 : n));
		issue(op, v, p);
	endtask

	initial begin
		logic [CAP_W-1:0] phase_cap[PHASES];
		int phase_grow[PHASES];
		int phase_clear[PHASES];
		mirror = new();
		phase_cap = '{7'd64, 7'd127, 7'd20, 7'd5, 7'd100, 7'd1, 7'd64, 7'd0, 7'd0, 7'd64};
		phase_cap[7] = CAP_W'($urandom_range(1, DEPTH));
		phase_grow = '{75, 80, 40, 30, 60, 50, 50, 45, 50, 45};
		phase_clear = '{0, 0, 1, 3, 0, 2, 1, 2, 2, 1};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on a three-entry list: empty-list errors first.
		write_capacity(7'd3);
		issue(OP_REMOVE_VAL, 32'h0, 6'd0);
		issue(OP_CONTAINS, 32'h0, 6'd0);
		issue(OP_GET, 32'h0, 6'd0);
		issue(OP_REMOVE_AT, 32'h0, 6'd0);
		issue(OP_SET, 32'h0, 6'd0);
		issue(OP_INSERT, 32'h1, 6'd1);
		issue(OP_INSERT, 32'hFFFF_FFFF, 6'd0);
		issue(OP_APPEND, 32'h0, 6'd0);
		// Inserting at the count position behaves as an append.
		issue(OP_INSERT, 32'h1234_5678, 6'd2);
		issue(OP_APPEND, 32'h5, 6'd0);
		issue(OP_INSERT, 32'h6, 6'd63);
		issue(OP_GET, 32'h0, 6'd63);
		issue(OP_GET, 32'h0, 6'd2);
		issue(OP_SET, 32'hA5A5_A5A5, 6'd1);
		issue(OP_CONTAINS, 32'hA5A5_A5A5, 6'd0);
		issue(OP_REMOVE_VAL, 32'hFFFF_FFFF, 6'd0);
		issue(OP_REMOVE_VAL, 32'h7, 6'd0);
		issue(OP_REMOVE_AT, 32'h0, 6'd2);
		issue(OP_REMOVE_AT, 32'h0, 6'd0);
		issue(OP_CLEAR, 32'h0, 6'd0);
		// Duplicates: only the first match goes away.
		issue(OP_APPEND, 32'h9, 6'd0);
		issue(OP_APPEND, 32'h9, 6'd0);
		issue(OP_REMOVE_VAL, 32'h9, 6'd0);
		issue(OP_GET, 32'h0, 6'd0);
		// A capacity of zero acts as one.
		write_capacity(7'd0);
		issue(OP_APPEND, 32'h1, 6'd0);
		issue(OP_INSERT, 32'h2, 6'd0);

		// The list is not cleared between phases, so lower capacities land below the count.
		for (int ph = 0; ph < PHASES; ph++) begin
			write_capacity(phase_cap[ph]);
			gaps_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
			stalls_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
			for (int k = 0; k < PHASE_ITEMS; k++)
				random_request(phase_grow[ph], phase_clear[ph]);
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.pending() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

[filelist.f]
hdl/bole_pkg.sv
hdl/bounded_ordered_list_engine_top.sv
tb/testbench.sv
